// ----- hdl/keyframe_curve_interpolator_top_macros.svh -----
// assertion macros for the keyframe curve interpolator checker
// no dependencies
`ifndef KEYFRAME_CURVE_INTERPOLATOR_TOP_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_TOP_MACROS_SVH
`define KCI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define KCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- hdl/kci_pkg.sv -----
// shared types, codes and constants of the keyframe curve interpolator
// no dependencies
package kci_pkg;
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int SPAN_MIN = 7;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_EVAL = 2'd0;
   localparam logic [1:0] CMD_ADD = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_NOP = 2'd3;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_MIN_TWO = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic signed [31:0] time_point;
      logic signed [31:0] key_value;
      logic [5:0] key_index;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] curve_value;
      logic [1:0] status;
      logic [6:0] entry_count;
   } rsp_word_type;
endpackage

// ----- hdl/kci_stream_if.sv -----
// valid/ready channel carrying one word of a given type
// no dependencies
interface kci_stream_if #(parameter type word_type = logic) (input logic clock);
   logic valid;
   logic ready;
   word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- hdl/keyframe_curve_interpolator_top.sv -----
// an unused, refused or empty-table word is answered without touching the table;
// add or remove shifts entries one by one; evaluate answers with the key value at or
// before the first key or at or after the last, else scans keys, then divides unless the span is under SPAN_MIN
// the engine holds one word at a time; reset: synchronous, empties table and queue
// top level of the keyframe curve interpolator
// depends on kci_pkg, kci_stream_if, kci_front, kci_engine
module keyframe_curve_interpolator_top import kci_pkg::*; (
   input logic clock,
   input logic reset,
   kci_stream_if.sink req,
   kci_stream_if.source rsp
);
   logic q_valid, q_ready;
   req_word_type q_word;

   kci_front u_front (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .in_word(req.word), .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
   );

   kci_engine u_engine (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_word(q_word), .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_word(rsp.word)
   );
endmodule

// ----- hdl/kci_front.sv -----
// front end: accepts command words and queues them for the engine
// depends on kci_pkg
module kci_front import kci_pkg::*; (
   input logic clock,
   input logic reset,
   input logic in_valid,
   output logic in_ready,
   input req_word_type in_word,
   output logic q_valid,
   input logic q_ready,
   output req_word_type q_word
);
   req_word_type mem_ff [QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic push, pop;

   assign in_ready = fill_ff != 2'(QUEUE_DEPTH);
   assign q_valid = fill_ff != 2'd0;
   assign q_word = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end
endmodule

// ----- hdl/kci_divider.sv -----
// restoring divider, 64-bit dividend by 33-bit divisor, one bit a cycle
// depends on kci_pkg
module kci_divider import kci_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [63:0] dividend,
   input logic [32:0] divisor,
   output logic busy,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in;
   logic [33:0] rem_ff, rem_in;
   logic [32:0] den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [33:0] trial;

   assign busy = cnt_ff != 7'd0;
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      trial = {rem_ff[32:0], quo_ff[63]};
      if (start) begin
         quo_in = dividend;
         rem_in = 34'd0;
         den_in = divisor;
         cnt_in = 7'd64;
      end else if (busy) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end
endmodule

// ----- hdl/kci_engine.sv -----
// back end: keyframe table, insert and remove shifting, curve evaluation
// depends on kci_pkg and kci_divider
module kci_engine import kci_pkg::*; (
   input logic clock,
   input logic reset,
   input logic q_valid,
   output logic q_ready,
   input req_word_type q_word,
   output logic out_valid,
   input logic out_ready,
   output rsp_word_type out_word
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ADD_RD = 4'd1;
   localparam logic [3:0] S_ADD_CMP = 4'd2;
   localparam logic [3:0] S_REM_RD = 4'd3;
   localparam logic [3:0] S_REM_WR = 4'd4;
   localparam logic [3:0] S_EV_RD = 4'd5;
   localparam logic [3:0] S_EV_CMP = 4'd6;
   localparam logic [3:0] S_MUL = 4'd7;
   localparam logic [3:0] S_DIV = 4'd8;
   localparam logic [3:0] S_DIV_WAIT = 4'd9;
   localparam logic [3:0] S_OUT = 4'd10;
   localparam logic [3:0] S_EV_LRD = 4'd11;
   localparam logic [3:0] S_EV_LCMP = 4'd12;

   logic [31:0] time_mem [TABLE_DEPTH];
   logic [31:0] value_mem [TABLE_DEPTH];
   logic [31:0] rd_t_ff, rd_v_ff;

   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   req_word_type cur_ff, cur_in;
   logic signed [31:0] prev_t_ff, prev_t_in, prev_v_ff, prev_v_in;
   logic prev_ok_ff, prev_ok_in;
   logic [31:0] mag_ff, mag_in, num_ff, num_in;
   logic [32:0] span_ff, span_in;
   logic neg_ff, neg_in;
   logic [63:0] prod_ff, prod_in;
   rsp_word_type rsp_ff, rsp_in;
   logic out_valid_ff, out_valid_in;

   logic rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [31:0] wr_t, wr_v;
   logic div_start, div_busy;
   logic [63:0] div_q;
   logic signed [32:0] diff;
   logic signed [31:0] tq;

   kci_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(prod_ff),
      .divisor(span_ff), .busy(div_busy), .quotient(div_q)
   );

   assign q_ready = state_ff == S_IDLE && !out_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      pos_in = pos_ff;
      cur_in = cur_ff;
      prev_t_in = prev_t_ff;
      prev_v_in = prev_v_ff;
      prev_ok_in = prev_ok_ff;
      mag_in = mag_ff;
      num_in = num_ff;
      span_in = span_ff;
      neg_in = neg_ff;
      prod_in = prod_ff;
      rsp_in = rsp_ff;
      out_valid_in = out_valid_ff;
      rd_en = 1'b0;
      rd_addr = pos_ff[IDX_W-1:0];
      wr_en = 1'b0;
      wr_addr = pos_ff[IDX_W-1:0];
      wr_t = cur_ff.time_point;
      wr_v = cur_ff.key_value;
      div_start = 1'b0;
      tq = cur_ff.time_point;
      diff = 33'(signed'(rd_v_ff)) - 33'(prev_v_ff);
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (q_valid && !out_valid_ff) begin
               cur_in = q_word;
               rsp_in = '{curve_value: 32'sd0, status: ST_DONE, entry_count: count_ff};
               prev_ok_in = 1'b0;
               case (q_word.command)
                  CMD_EVAL: begin
                     if (count_ff == '0) begin
                        state_in = S_OUT;
                     end else begin
                        pos_in = '0;
                        state_in = S_EV_RD;
                     end
                  end
                  CMD_ADD: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        rsp_in.status = ST_FULL;
                        state_in = S_OUT;
                     end else begin
                        pos_in = count_ff;
                        state_in = S_ADD_RD;
                     end
                  end
                  CMD_REMOVE: begin
                     if (CNT_W'(q_word.key_index) >= count_ff) begin
                        rsp_in.status = ST_RANGE;
                        state_in = S_OUT;
                     end else if (count_ff <= CNT_W'(2)) begin
                        rsp_in.status = ST_MIN_TWO;
                        state_in = S_OUT;
                     end else begin
                        pos_in = CNT_W'(q_word.key_index);
                        state_in = S_REM_RD;
                     end
                  end
                  default: begin
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.entry_count = 7'(count_ff + 1'b1);
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               rd_addr = IDX_W'(pos_ff - 1'b1);
               state_in = S_ADD_CMP;
            end
         end
         S_ADD_CMP: begin
            if ($signed(rd_t_ff) > cur_ff.time_point) begin
               wr_en = 1'b1;
               wr_t = rd_t_ff;
               wr_v = rd_v_ff;
               pos_in = pos_ff - 1'b1;
               state_in = S_ADD_RD;
            end else begin
               wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               rsp_in.entry_count = 7'(count_ff + 1'b1);
               state_in = S_OUT;
            end
         end
         S_REM_RD: begin
            if (pos_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               rsp_in.entry_count = 7'(count_ff - 1'b1);
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               rd_addr = IDX_W'(pos_ff + 1'b1);
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            wr_en = 1'b1;
            wr_t = rd_t_ff;
            wr_v = rd_v_ff;
            pos_in = pos_ff + 1'b1;
            state_in = S_REM_RD;
         end
         S_EV_RD: begin
            rd_en = 1'b1;
            state_in = S_EV_CMP;
         end
         S_EV_CMP: begin
            if (!prev_ok_ff && tq <= $signed(rd_t_ff)) begin
               rsp_in.curve_value = rd_v_ff;
               state_in = S_OUT;
            end else if (!prev_ok_ff) begin
               // past the first key, check the last key before scanning
               prev_ok_in = 1'b1;
               prev_t_in = rd_t_ff;
               prev_v_in = rd_v_ff;
               pos_in = count_ff - 1'b1;
               state_in = S_EV_LRD;
            end else if (tq <= $signed(rd_t_ff)) begin
               span_in = 33'($signed(rd_t_ff)) - 33'(prev_t_ff);
               num_in = 32'(33'(tq) - 33'(prev_t_ff));
               neg_in = diff < 0;
               mag_in = diff < 0 ? 32'(-diff) : 32'(diff);
               if (33'($signed(rd_t_ff)) - 33'(prev_t_ff) < 33'(SPAN_MIN)) begin
                  rsp_in.curve_value = prev_v_ff;
                  state_in = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end else if (pos_ff + 1'b1 >= count_ff) begin
               rsp_in.curve_value = rd_v_ff;
               state_in = S_OUT;
            end else begin
               prev_t_in = rd_t_ff;
               prev_v_in = rd_v_ff;
               pos_in = pos_ff + 1'b1;
               state_in = S_EV_RD;
            end
         end
         S_EV_LRD: begin
            rd_en = 1'b1;
            state_in = S_EV_LCMP;
         end
         S_EV_LCMP: begin
            if (tq >= $signed(rd_t_ff)) begin
               rsp_in.curve_value = rd_v_ff;
               state_in = S_OUT;
            end else begin
               pos_in = CNT_W'(1);
               state_in = S_EV_RD;
            end
         end
         S_MUL: begin
            prod_in = 64'(mag_ff) * 64'(num_ff);
            state_in = S_DIV;
         end
         S_DIV: begin
            div_start = 1'b1;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!div_busy) begin
               rsp_in.curve_value = neg_ff ? prev_v_ff - div_q[31:0]
                                           : prev_v_ff + div_q[31:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            out_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_valid_ff <= out_valid_in;
      end
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      prev_t_ff <= prev_t_in;
      prev_v_ff <= prev_v_in;
      prev_ok_ff <= prev_ok_in;
      mag_ff <= mag_in;
      num_ff <= num_in;
      span_ff <= span_in;
      neg_ff <= neg_in;
      prod_ff <= prod_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr] <= wr_t;
         value_mem[wr_addr] <= wr_v;
      end
      if (rd_en) begin
         rd_t_ff <= time_mem[rd_addr];
         rd_v_ff <= value_mem[rd_addr];
      end
   end
endmodule

// ----- hdl/kci_checker.sv -----
// port checker for the keyframe curve interpolator and its bind
// depends on kci_pkg and keyframe_curve_interpolator_top_macros.svh
`include "keyframe_curve_interpolator_top_macros.svh"
module kci_checker import kci_pkg::*; (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_word_type rsp_word
);
   `KCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "rsp word dropped while stalled")
   `KCI_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_word.entry_count <= 7'(TABLE_DEPTH), "entry count above depth")
   `KCI_ASSERT_IMPL(a_full_count, clock, reset, rsp_valid && rsp_word.status == ST_FULL, rsp_word.entry_count == 7'(TABLE_DEPTH), "full status with room left")
   `KCI_ASSERT_IMPL(a_min_two, clock, reset, rsp_valid && rsp_word.status == ST_MIN_TWO, rsp_word.entry_count <= 7'd2, "min two status with more entries")
endmodule

bind keyframe_curve_interpolator_top kci_checker u_kci_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word(rsp.word)
);
